// File: design/dcrt_pkg.sv
package dcrt_pkg;

    // Default counter width
    localparam int DEFAULT_COUNT_WIDTH = 16;

    // Field widths
    localparam int CMD_W       = 2;
    localparam int SEL_W       = 3;
    localparam int DATA_W      = 16;
    localparam int PRESCALE_W  = 16;

    // Stream widths
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = CMD_W + SEL_W;
    localparam int M_TDATA_W   = 24;

    // Configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Configuration register indexes
    localparam logic CFG_PRESCALE  = 1'b0;
    localparam logic CFG_UOU       = 1'b1;

    // Control register bit positions
    localparam int CTRL_ENABLE     = 0;
    localparam int CTRL_UPD_DIS    = 1;
    localparam int CTRL_UOU        = 2;
    localparam int CTRL_ONE_SHOT   = 3;

    typedef enum logic [CMD_W-1:0]
    {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [SEL_W-1:0]
    {
        SEL_CONTROL = 3'd0,
        SEL_IRQ_EN  = 3'd1,
        SEL_STATUS  = 3'd2,
        SEL_EVENT   = 3'd3,
        SEL_COUNTER = 3'd4,
        SEL_RELOAD  = 3'd5
    } sel_t;

    typedef struct packed
    {
        logic [PRESCALE_W-1:0] prescale_value;
        logic                  underflow_only_update;
    } cfg_t;

endpackage

// File: design/dcrt_cfg.sv
module dcrt_cfg
    import dcrt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [PRESCALE_W-1:0] prescale_reg;
    logic                  uou_reg;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= '0;
            uou_reg      <= 1'b0;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                CFG_PRESCALE: prescale_reg <= pwdata[PRESCALE_W-1:0];
                CFG_UOU:      uou_reg      <= pwdata[0];
                default:      ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (paddr[2])
            CFG_PRESCALE: prdata = APB_DATA_W'(prescale_reg);
            CFG_UOU:      prdata = APB_DATA_W'(uou_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.prescale_value        = prescale_reg;
    assign cfg.underflow_only_update = uou_reg;

endmodule

// File: design/dcrt_core.sv
module dcrt_core
    import dcrt_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              advance,
    input  logic [CMD_W-1:0]  command,
    input  logic [SEL_W-1:0]  reg_select,
    input  logic [DATA_W-1:0] write_value,
    output logic [DATA_W-1:0] read_value,
    output logic              irq_pending
);

    logic [COUNT_WIDTH-1:0] count_reg,    count_next;
    logic [PRESCALE_W-1:0]  prescale_reg, prescale_next;
    logic [COUNT_WIDTH-1:0] reload_reg,   reload_next;
    logic                   enable_reg,   enable_next;
    logic                   upd_dis_reg,  upd_dis_next;
    logic                   one_shot_reg, one_shot_next;
    logic                   irq_en_reg,   irq_en_next;
    logic                   flag_reg,     flag_next;

    logic [COUNT_WIDTH-1:0] wv_count;
    logic [31:0]            wv_wide;

    // Resize write data to the counter width
    assign wv_wide  = 32'(write_value);
    assign wv_count = COUNT_WIDTH'(wv_wide);

    // Next state and read data for the current transaction
    always_comb
    begin
        count_next    = count_reg;
        prescale_next = prescale_reg;
        reload_next   = reload_reg;
        enable_next   = enable_reg;
        upd_dis_next  = upd_dis_reg;
        one_shot_next = one_shot_reg;
        irq_en_next   = irq_en_reg;
        flag_next     = flag_reg;
        read_value    = '0;

        case (cmd_t'(command))
            CMD_TICK:
            begin
                if (enable_reg)
                begin
                    if (prescale_reg >= cfg.prescale_value)
                    begin
                        prescale_next = '0;
                        if (count_reg == '0)
                        begin
                            count_next = reload_reg;
                            if (!upd_dis_reg)
                            begin
                                flag_next = 1'b1;
                                if (one_shot_reg)
                                    enable_next = 1'b0;
                            end
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        prescale_next = prescale_reg + 1'b1;
                    end
                end
            end
            CMD_WRITE:
            begin
                case (sel_t'(reg_select))
                    SEL_CONTROL:
                    begin
                        enable_next   = write_value[CTRL_ENABLE];
                        upd_dis_next  = write_value[CTRL_UPD_DIS];
                        one_shot_next = write_value[CTRL_ONE_SHOT];
                    end
                    SEL_IRQ_EN:  irq_en_next = write_value[0];
                    SEL_STATUS:
                    begin
                        if (!write_value[0])
                            flag_next = 1'b0;
                    end
                    SEL_EVENT:
                    begin
                        if (write_value[0])
                        begin
                            count_next    = reload_reg;
                            prescale_next = '0;
                            if (!upd_dis_reg && !cfg.underflow_only_update)
                                flag_next = 1'b1;
                        end
                    end
                    SEL_COUNTER: count_next  = wv_count;
                    SEL_RELOAD:  reload_next = wv_count;
                    default:     ;
                endcase
            end
            CMD_READ:
            begin
                case (sel_t'(reg_select))
                    SEL_CONTROL:
                    begin
                        read_value[CTRL_ENABLE]   = enable_reg;
                        read_value[CTRL_UPD_DIS]  = upd_dis_reg;
                        read_value[CTRL_UOU]      = cfg.underflow_only_update;
                        read_value[CTRL_ONE_SHOT] = one_shot_reg;
                    end
                    SEL_IRQ_EN:  read_value[0] = irq_en_reg;
                    SEL_STATUS:  read_value[0] = flag_reg;
                    SEL_COUNTER: read_value = DATA_W'(32'(count_reg));
                    SEL_RELOAD:  read_value = DATA_W'(32'(reload_reg));
                    default:     read_value = '0;
                endcase
            end
            default: ;
        endcase

        irq_pending = flag_next & irq_en_next;
    end

    // Commit state when the transaction moves to the output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            prescale_reg <= '0;
            reload_reg   <= '0;
            enable_reg   <= 1'b0;
            upd_dis_reg  <= 1'b0;
            one_shot_reg <= 1'b0;
            irq_en_reg   <= 1'b0;
            flag_reg     <= 1'b0;
        end
        else if (advance)
        begin
            count_reg    <= count_next;
            prescale_reg <= prescale_next;
            reload_reg   <= reload_next;
            enable_reg   <= enable_next;
            upd_dis_reg  <= upd_dis_next;
            one_shot_reg <= one_shot_next;
            irq_en_reg   <= irq_en_next;
            flag_reg     <= flag_next;
        end
    end

endmodule

// File: design/down_counting_reload_timer.sv
// Down-counting auto-reload timer driven by a stream of transactions.
// Slave stream: each transaction is a clock tick, a register write or a
//   register read. s_tuser carries command and register select, s_tdata
//   carries the write data.
// Master stream: exactly one result per input transaction, in order:
//   read data (zero unless a read) and the interrupt line after the
//   transaction.
// The result passes through the input register, then the result register,
//   and waits in the input register while the result register is full.
//   Throughput: one transaction per cycle while the receiver takes results,
//   set by the combinational update of the timer state between the two registers.
// When the receiver stalls, the result register holds and the input
//   register still takes one more transaction; s_tready drops once both
//   are full and rises in the same cycle m_tready takes the result.
// APB port: prescale value at address 0, underflow-only-update at
//   address 4; pready is always high. Write it only while no transaction
//   is in flight.
// Reset clears all timer state, both configuration registers and both
//   pipeline valid flags, so s_tready is high as soon as reset is applied.
module down_counting_reload_timer
    import dcrt_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // slave stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // [15:0] write_value
    input  logic [S_TUSER_W-1:0]  s_tuser,  // [1:0] command, [4:2] reg_select
    // master stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // [15:0] read_value, [16] irq_pending
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t              cfg;
    logic              in_valid_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [SEL_W-1:0]  sel_reg;
    logic [DATA_W-1:0] wdata_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic              irq_reg;
    logic [DATA_W-1:0] rdata_next;
    logic              irq_next;
    logic              out_free;
    logic              advance;

    dcrt_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dcrt_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .advance     (advance),
        .command     (cmd_reg),
        .reg_select  (sel_reg),
        .write_value (wdata_reg),
        .read_value  (rdata_next),
        .irq_pending (irq_next)
    );

    // Pipeline handshake
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            cmd_reg   <= s_tuser[CMD_W-1:0];
            sel_reg   <= s_tuser[CMD_W +: SEL_W];
            wdata_reg <= s_tdata[DATA_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rdata_reg <= rdata_next;
            irq_reg   <= irq_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-DATA_W-1){1'b0}}, irq_reg, rdata_reg};

endmodule
